### rtl/core/cvrl_pkg.sv
// Shared types and constants for the charger voltage request loop.
// Used by cvrl_update and charger_voltage_request_loop_unit; no dependencies.
package cvrl_pkg;

	// Field widths
	localparam int unsigned CellW   = 16;
	localparam int unsigned AmpW    = 10;
	localparam int unsigned VoltW   = 10;
	localparam int unsigned PeriodW = 8;
	localparam int unsigned StepW   = 6;
	localparam int unsigned CfgIdxW = 4;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 24;

	// Loop constants
	localparam logic [VoltW-1:0]   VREQ_RESET     = 10'd540;
	localparam logic [VoltW-1:0]   VREQ_MAX       = 10'd1023;
	localparam logic [13:0]        CURRENT_MARGIN = 14'd12;
	localparam logic [VoltW:0]     VOLTAGE_MARGIN = 11'd4;
	localparam logic [AmpW-1:0]    AMP_SCALE      = 10'd10;
	localparam logic [AmpW-1:0]    MIN_FLOW       = 10'd2;
	localparam logic signed [11:0] STEP_UP        = 12'sd1;
	localparam logic signed [11:0] STEP_DOWN      = -12'sd5;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_CURRENT_REQUEST = 4'd0,
		REG_PERIOD_TICKS    = 4'd1,
		REG_CELL_LOW_LIMIT  = 4'd2,
		REG_CELL_HIGH_LIMIT = 4'd3,
		REG_VOLTAGE_FLOOR   = 4'd4,
		REG_REST_VOLTAGE    = 4'd5,
		REG_BALANCE_CURRENT = 4'd6,
		REG_NO_CURRENT_STEP = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [AmpW-1:0]    current_request;
		logic [PeriodW-1:0] period_ticks;
		logic [CellW-1:0]   cell_low_limit;
		logic [CellW-1:0]   cell_high_limit;
		logic [VoltW-1:0]   voltage_floor;
		logic [VoltW-1:0]   rest_voltage;
		logic [AmpW-1:0]    balance_current;
		logic [StepW-1:0]   no_current_step;
	} cfg_t;

	typedef struct packed {
		logic               activation;
		logic               balancing;
		logic [CellW-1:0]   cell_max_voltage;
		logic [AmpW-1:0]    charger_current;
		logic [VoltW-1:0]   charger_voltage;
	} tick_t;

	typedef struct packed {
		logic [VoltW-1:0]   voltage_request;
		logic [PeriodW-1:0] period_count;
	} loop_state_t;

	typedef struct packed {
		logic [VoltW-1:0]   voltage_command;
		logic [AmpW-1:0]    current_command;
		logic               charger_enable;
	} command_t;

	typedef struct packed {
		command_t    cmd;
		loop_state_t next_state;
	} update_t;

endpackage

### rtl/core/cvrl_update.sv
// Combinational per-tick update: charger command and next loop state.
// Depends on cvrl_pkg.
module cvrl_update (
	input  cvrl_pkg::cfg_t        cfg,
	input  cvrl_pkg::loop_state_t state,
	input  cvrl_pkg::tick_t       tick,
	output cvrl_pkg::update_t     upd
);

	logic                    due;
	logic [13:0]             amp_scaled;
	logic                    room;
	logic                    cell_high;
	logic signed [11:0]      step;
	logic signed [11:0]      cell_sum;
	logic [cvrl_pkg::VoltW-1:0] cell_req;
	logic [cvrl_pkg::VoltW:0]   boost_sum;
	logic [cvrl_pkg::VoltW-1:0] boost_req;
	logic [cvrl_pkg::VoltW-1:0] adj_req;

	// Adjustment conditions
	assign due        = state.period_count > cfg.period_ticks;
	assign amp_scaled = 14'(tick.charger_current) * 14'(cvrl_pkg::AMP_SCALE);
	assign room       = (14'(cfg.current_request) > amp_scaled + cvrl_pkg::CURRENT_MARGIN)
		&& ({1'b0, state.voltage_request}
			< {1'b0, tick.charger_voltage} + cvrl_pkg::VOLTAGE_MARGIN)
		&& (tick.charger_current >= cvrl_pkg::MIN_FLOW);
	assign cell_high  = tick.cell_max_voltage > cfg.cell_high_limit;

	// Cell-driven step, low limit first
	always_comb begin
		if (tick.cell_max_voltage < cfg.cell_low_limit) begin
			step = cvrl_pkg::STEP_UP;
		end else if (cell_high) begin
			step = cvrl_pkg::STEP_DOWN;
		end else begin
			step = '0;
		end
	end

	// Apply step, hold at the floor, saturate at the top
	assign cell_sum = $signed({2'b00, state.voltage_request}) + step;
	always_comb begin
		if (cell_sum < $signed({2'b00, cfg.voltage_floor})) begin
			cell_req = cfg.voltage_floor;
		end else if (cell_sum > $signed({2'b00, cvrl_pkg::VREQ_MAX})) begin
			cell_req = cvrl_pkg::VREQ_MAX;
		end else begin
			cell_req = cell_sum[cvrl_pkg::VoltW-1:0];
		end
	end

	// No-current boost, saturating
	assign boost_sum = {1'b0, state.voltage_request} + 11'(cfg.no_current_step);
	assign boost_req = boost_sum[cvrl_pkg::VoltW] ? cvrl_pkg::VREQ_MAX
		: boost_sum[cvrl_pkg::VoltW-1:0];

	always_comb begin
		if (room || cell_high) begin
			adj_req = cell_req;
		end else if (tick.charger_current < cvrl_pkg::MIN_FLOW) begin
			adj_req = boost_req;
		end else begin
			adj_req = state.voltage_request;
		end
	end

	// Select command and next state by mode
	always_comb begin
		upd.next_state = state;
		if (tick.activation && !tick.balancing) begin
			upd.next_state.voltage_request = due ? adj_req : state.voltage_request;
			upd.next_state.period_count    = due ? 8'd1 : state.period_count + 8'd1;
			upd.cmd.voltage_command        = upd.next_state.voltage_request;
			upd.cmd.current_command        = cfg.current_request;
			upd.cmd.charger_enable         = 1'b1;
		end else if (tick.activation) begin
			upd.cmd.voltage_command = cfg.rest_voltage;
			upd.cmd.current_command = cfg.balance_current;
			upd.cmd.charger_enable  = 1'b1;
		end else begin
			upd.next_state.voltage_request = cfg.rest_voltage;
			upd.cmd.voltage_command        = cfg.rest_voltage;
			upd.cmd.current_command        = '0;
			upd.cmd.charger_enable         = 1'b0;
		end
	end

endmodule

### rtl/core/charger_voltage_request_loop_unit.sv
// Charger voltage request loop top level: stream ports, config registers,
// input and result registers. Depends on cvrl_pkg and cvrl_update.
//
// One charger command leaves for every control tick taken in. Ticks are
// taken one per clock when the output is not stalled; a tick is held in
// the input register and its command then sits in the result register
// until taken. The loop state updates as a tick leaves the input register,
// so back-to-back ticks see each other's effect. Configuration writes are
// always ready and must only occur while the block is idle.
module charger_voltage_request_loop_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Control ticks
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [0] activation, [1] balancing, [17:2] cell_max_voltage,
	// [27:18] charger_current, [37:28] charger_voltage, [39:38] zero
	input  logic [cvrl_pkg::InDataW-1:0]    s_axis_tdata,
	// Charger commands
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [9:0] voltage_command, [19:10] current_command, [20] charger_enable,
	// [23:21] zero
	output logic [cvrl_pkg::OutDataW-1:0]   m_axis_tdata,
	// Configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cvrl_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [cvrl_pkg::CfgDataW-1:0]   cfg_data
);

	cvrl_pkg::cfg_t        cfg_q;
	cvrl_pkg::loop_state_t state_q;
	cvrl_pkg::tick_t       tick_s1;
	logic                  valid_s1;
	cvrl_pkg::command_t    cmd_q;
	logic                  out_valid_q;
	cvrl_pkg::update_t     upd;
	logic                  advance;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_request <= 10'd300;
			cfg_q.period_ticks    <= 8'd60;
			cfg_q.cell_low_limit  <= 16'd34500;
			cfg_q.cell_high_limit <= 16'd34850;
			cfg_q.voltage_floor   <= 10'd530;
			cfg_q.rest_voltage    <= 10'd584;
			cfg_q.balance_current <= 10'd7;
			cfg_q.no_current_step <= 6'd7;
		end else if (cfg_valid) begin
			case (cvrl_pkg::cfg_reg_t'(cfg_index))
				cvrl_pkg::REG_CURRENT_REQUEST: cfg_q.current_request <= cfg_data[9:0];
				cvrl_pkg::REG_PERIOD_TICKS:    cfg_q.period_ticks    <= cfg_data[7:0];
				cvrl_pkg::REG_CELL_LOW_LIMIT:  cfg_q.cell_low_limit  <= cfg_data;
				cvrl_pkg::REG_CELL_HIGH_LIMIT: cfg_q.cell_high_limit <= cfg_data;
				cvrl_pkg::REG_VOLTAGE_FLOOR:   cfg_q.voltage_floor   <= cfg_data[9:0];
				cvrl_pkg::REG_REST_VOLTAGE:    cfg_q.rest_voltage    <= cfg_data[9:0];
				cvrl_pkg::REG_BALANCE_CURRENT: cfg_q.balance_current <= cfg_data[9:0];
				cvrl_pkg::REG_NO_CURRENT_STEP: cfg_q.no_current_step <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on when the result register is free or being taken
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tick_s1.activation       <= s_axis_tdata[0];
			tick_s1.balancing        <= s_axis_tdata[1];
			tick_s1.cell_max_voltage <= s_axis_tdata[17:2];
			tick_s1.charger_current  <= s_axis_tdata[27:18];
			tick_s1.charger_voltage  <= s_axis_tdata[37:28];
		end
	end

	cvrl_update u_update (
		.cfg   (cfg_q),
		.state (state_q),
		.tick  (tick_s1),
		.upd   (upd)
	);

	// Loop state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.voltage_request <= cvrl_pkg::VREQ_RESET;
			state_q.period_count    <= '0;
			out_valid_q             <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= upd.next_state;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_q <= upd.cmd;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, cmd_q.charger_enable, cmd_q.current_command,
		cmd_q.voltage_command};

endmodule

### sim/charger_voltage_request_loop_unit_tb.sv
// Self-checking bench for charger_voltage_request_loop_unit: drives control ticks and
// config writes, predicts each charger command and compares what comes out.
// Depends on cvrl_pkg and the charger_voltage_request_loop_unit RTL.
module charger_voltage_request_loop_unit_tb;

	// Loop constants of the predictor
	localparam int REQUEST_AT_RESET = 540;
	localparam int REQUEST_TOP      = 1023;
	localparam int AMP_MARGIN       = 12;
	localparam int VOLT_MARGIN      = 4;
	localparam int AMP_FACTOR       = 10;
	localparam int FLOW_MIN         = 2;
	localparam int CELL_STEP_UP     = 1;
	localparam int CELL_STEP_DOWN   = -5;

	// First register index that maps to nothing
	localparam logic [3:0] FIRST_UNUSED_INDEX = 4'd8;

	localparam cvrl_pkg::cfg_t CFG_AT_RESET = '{
		current_request: 10'd300, period_ticks: 8'd60,
		cell_low_limit: 16'd34500, cell_high_limit: 16'd34850,
		voltage_floor: 10'd530, rest_voltage: 10'd584,
		balance_current: 10'd7, no_current_step: 6'd7};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Predictor state and shadow of the config registers
	cvrl_pkg::cfg_t     loop_cfg = CFG_AT_RESET;
	logic [9:0]         loop_request = 10'(REQUEST_AT_RESET);
	logic [7:0]         loop_period = '0;
	cvrl_pkg::command_t owed_commands[$];
	int                 errors = 0;
	int                 snd_idle_pct = 0;
	int                 rcv_stall_pct = 0;

	charger_voltage_request_loop_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Work out the command for one tick and advance the loop state
	function automatic cvrl_pkg::command_t charger_command_for(cvrl_pkg::tick_t t);
		cvrl_pkg::command_t cmd;
		int req, amps, volts, creq, cell_step, next_req;
		logic room;
		req = loop_request;
		amps = t.charger_current;
		volts = t.charger_voltage;
		creq = loop_cfg.current_request;
		next_req = req;
		if (t.activation && !t.balancing) begin
			if (loop_period > loop_cfg.period_ticks) begin
				room = (creq - amps * AMP_FACTOR > AMP_MARGIN) && (req - volts < VOLT_MARGIN)
					&& (amps >= FLOW_MIN);
				loop_period = '0;
				if (room || t.cell_max_voltage > loop_cfg.cell_high_limit) begin
					if (t.cell_max_voltage < loop_cfg.cell_low_limit)
						cell_step = CELL_STEP_UP;
					else if (t.cell_max_voltage > loop_cfg.cell_high_limit)
						cell_step = CELL_STEP_DOWN;
					else
						cell_step = 0;
					next_req = req + cell_step;
					if (next_req < int'(loop_cfg.voltage_floor))
						next_req = loop_cfg.voltage_floor;
				end else if (amps < FLOW_MIN) begin
					next_req = req + int'(loop_cfg.no_current_step);
				end
				if (next_req > REQUEST_TOP)
					next_req = REQUEST_TOP;
				loop_request = 10'(next_req);
			end
			cmd.voltage_command = loop_request;
			cmd.current_command = loop_cfg.current_request;
			cmd.charger_enable = 1'b1;
			loop_period = loop_period + 8'd1;
		end else if (t.activation) begin
			cmd.voltage_command = loop_cfg.rest_voltage;
			cmd.current_command = loop_cfg.balance_current;
			cmd.charger_enable = 1'b1;
		end else begin
			cmd.voltage_command = loop_cfg.rest_voltage;
			cmd.current_command = '0;
			cmd.charger_enable = 1'b0;
			loop_request = loop_cfg.rest_voltage;
		end
		return cmd;
	endfunction

	// Put random junk above the register width
	function automatic logic [15:0] with_junk(int unsigned value, int unsigned width);
		logic [15:0] junk;
		junk = 16'($urandom);
		if (width < 16)
			junk = (junk >> width) << width;
		else
			junk = '0;
		return junk | 16'(value);
	endfunction

	// Send one tick, idling first at the configured rate
	task automatic send_tick(logic act, logic bal, logic [15:0] cell_v, logic [9:0] amps,
		logic [9:0] volts);
		cvrl_pkg::tick_t t;
		t = '{activation: act, balancing: bal, cell_max_voltage: cell_v,
			charger_current: amps, charger_voltage: volts};
		while ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, volts, amps, cell_v, bal, act};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		owed_commands.push_back(charger_command_for(t));
	endtask

	// Drop valid and wait until every owed command has arrived
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (owed_commands.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; only called while the block is idle
	task automatic write_reg(logic [3:0] idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			cvrl_pkg::REG_CURRENT_REQUEST: loop_cfg.current_request = value[9:0];
			cvrl_pkg::REG_PERIOD_TICKS:    loop_cfg.period_ticks = value[7:0];
			cvrl_pkg::REG_CELL_LOW_LIMIT:  loop_cfg.cell_low_limit = value;
			cvrl_pkg::REG_CELL_HIGH_LIMIT: loop_cfg.cell_high_limit = value;
			cvrl_pkg::REG_VOLTAGE_FLOOR:   loop_cfg.voltage_floor = value[9:0];
			cvrl_pkg::REG_REST_VOLTAGE:    loop_cfg.rest_voltage = value[9:0];
			cvrl_pkg::REG_BALANCE_CURRENT: loop_cfg.balance_current = value[9:0];
			cvrl_pkg::REG_NO_CURRENT_STEP: loop_cfg.no_current_step = value[5:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(cvrl_pkg::cfg_t c);
		write_reg(cvrl_pkg::REG_CURRENT_REQUEST, with_junk(c.current_request, 10));
		write_reg(cvrl_pkg::REG_PERIOD_TICKS, with_junk(c.period_ticks, 8));
		write_reg(cvrl_pkg::REG_CELL_LOW_LIMIT, with_junk(c.cell_low_limit, 16));
		write_reg(cvrl_pkg::REG_CELL_HIGH_LIMIT, with_junk(c.cell_high_limit, 16));
		write_reg(cvrl_pkg::REG_VOLTAGE_FLOOR, with_junk(c.voltage_floor, 10));
		write_reg(cvrl_pkg::REG_REST_VOLTAGE, with_junk(c.rest_voltage, 10));
		write_reg(cvrl_pkg::REG_BALANCE_CURRENT, with_junk(c.balance_current, 10));
		write_reg(cvrl_pkg::REG_NO_CURRENT_STEP, with_junk(c.no_current_step, 6));
	endtask

	// Settings biased toward short periods and limits near the defaults
	function automatic cvrl_pkg::cfg_t random_setting();
		cvrl_pkg::cfg_t c;
		int r;
		r = $urandom_range(99);
		c.current_request = r < 25 ? 10'($urandom_range(20, 60)) : r < 35 ? 10'd0 :
			r < 45 ? 10'd1023 : 10'($urandom);
		r = $urandom_range(99);
		c.period_ticks = r < 80 ? 8'($urandom_range(0, 3)) : r < 88 ? 8'd60 :
			r < 94 ? 8'd254 : 8'($urandom);
		r = $urandom_range(99);
		c.cell_low_limit = r < 60 ? 16'(34400 + $urandom_range(0, 200)) : 16'($urandom);
		r = $urandom_range(99);
		c.cell_high_limit = r < 60 ? 16'(34750 + $urandom_range(0, 200)) : 16'($urandom);
		r = $urandom_range(99);
		c.voltage_floor = r < 40 ? 10'($urandom) : r < 60 ? 10'd0 : r < 80 ? 10'd530 :
			10'($urandom_range(990, 1023));
		r = $urandom_range(99);
		c.rest_voltage = r < 50 ? 10'($urandom) : 10'($urandom_range(980, 1023));
		c.balance_current = 10'($urandom);
		r = $urandom_range(99);
		c.no_current_step = r < 30 ? 6'd63 : 6'($urandom);
		return c;
	endfunction

	// Random tick: mostly charging, fields clustered where the rules switch
	task automatic send_random_tick();
		logic act, bal;
		logic [15:0] cell_v;
		logic [9:0] amps, volts;
		int r;
		act = $urandom_range(99) < 88;
		bal = $urandom_range(99) < 12;
		r = $urandom_range(99);
		if (r < 35)
			cell_v = 16'(int'(loop_cfg.cell_low_limit) + int'($urandom_range(0, 6)) - 3);
		else if (r < 65)
			cell_v = 16'(int'(loop_cfg.cell_high_limit) + int'($urandom_range(0, 6)) - 3);
		else
			cell_v = 16'($urandom);
		r = $urandom_range(99);
		if (r < 35)
			amps = 10'($urandom_range(0, 3));
		else if (r < 65)
			amps = 10'(int'(loop_cfg.current_request) / AMP_FACTOR
				+ int'($urandom_range(0, 4)) - 2);
		else
			amps = 10'($urandom);
		if ($urandom_range(99) < 50)
			volts = 10'(int'(loop_request) + int'($urandom_range(0, 8)) - 6);
		else
			volts = 10'($urandom);
		send_tick(act, bal, cell_v, amps, volts);
	endtask

	// Reset values: each mode twice, field extremes
	task automatic test_reset_values();
		send_tick(1'b1, 1'b0, 16'd0, 10'd0, 10'd0);
		send_tick(1'b1, 1'b1, 16'hFFFF, 10'd1023, 10'd1023);
		send_tick(1'b0, 1'b0, 16'hFFFF, 10'd1023, 10'd1023);
		send_tick(1'b0, 1'b1, 16'd0, 10'd0, 10'd0);
		send_tick(1'b1, 1'b0, 16'hFFFF, 10'd1023, 10'd1023);
		send_tick(1'b1, 1'b1, 16'd0, 10'd0, 10'd0);
		wait_drained();
	endtask

	// Every adjustment rule, its boundaries, floor and saturation
	task automatic test_adjust_rules();
		write_reg(cvrl_pkg::REG_PERIOD_TICKS, with_junk(0, 8));
		// room with cell below, then between the limits
		send_tick(1'b1, 1'b0, 16'd0, 10'd5, 10'd1023);
		send_tick(1'b1, 1'b0, 16'd34600, 10'd5, 10'd1023);
		send_tick(1'b1, 1'b0, 16'd34600, 10'd5, 10'd1023);
		// high cell without room, then no-current raises
		send_tick(1'b1, 1'b0, 16'hFFFF, 10'd0, 10'd0);
		send_tick(1'b1, 1'b0, 16'd34600, 10'd0, 10'd0);
		send_tick(1'b1, 1'b0, 16'd34600, 10'd1, 10'd0);
		// current of two: no raise, room only with voltage close
		send_tick(1'b1, 1'b0, 16'd34600, 10'd2, 10'd0);
		send_tick(1'b1, 1'b0, 16'd34499, 10'd2, 10'd1023);
		send_tick(1'b1, 1'b0, 16'd34851, 10'd1023, 10'd1023);
		// current margin edge, then voltage margin edge
		send_tick(1'b1, 1'b0, 16'd0, 10'd29, 10'd1023);
		send_tick(1'b1, 1'b0, 16'd0, 10'd28, 10'(int'(loop_request) - 3));
		send_tick(1'b1, 1'b0, 16'd0, 10'd28, 10'(int'(loop_request) - 4));
		wait_drained();
		write_reg(cvrl_pkg::REG_VOLTAGE_FLOOR, with_junk(1023, 10));
		send_tick(1'b1, 1'b0, 16'hFFFF, 10'd0, 10'd0);
		send_tick(1'b1, 1'b0, 16'd0, 10'd5, 10'd1023);
		wait_drained();
		write_reg(cvrl_pkg::REG_VOLTAGE_FLOOR, with_junk(0, 10));
		write_reg(cvrl_pkg::REG_NO_CURRENT_STEP, with_junk(63, 6));
		write_reg(cvrl_pkg::REG_CELL_LOW_LIMIT, with_junk(0, 16));
		write_reg(cvrl_pkg::REG_CELL_HIGH_LIMIT, with_junk(0, 16));
		send_tick(1'b1, 1'b0, 16'd0, 10'd0, 10'd0);
		send_tick(1'b1, 1'b0, 16'd0, 10'd0, 10'd0);
		wait_drained();
		// writes to unused indexes must change nothing
		write_reg(FIRST_UNUSED_INDEX, 16'hFFFF);
		write_reg(FIRST_UNUSED_INDEX + 4'd7, 16'hFFFF);
		write_reg(cvrl_pkg::REG_REST_VOLTAGE, with_junk(1023, 10));
		send_tick(1'b0, 1'b0, 16'd0, 10'd0, 10'd0);
		send_tick(1'b1, 1'b1, 16'd0, 10'd0, 10'd0);
		send_tick(1'b1, 1'b0, 16'd34600, 10'd0, 10'd0);
		send_tick(1'b1, 1'b0, 16'd34600, 10'd0, 10'd0);
		wait_drained();
	endtask

	// Period of 255 never adjusts and the counter wraps; 254 adjusts once per 255
	task automatic test_counter_wrap();
		cvrl_pkg::cfg_t c;
		c = random_setting();
		c.period_ticks = 8'd255;
		apply_setting(c);
		repeat (270) send_random_tick();
		wait_drained();
		write_reg(cvrl_pkg::REG_PERIOD_TICKS, with_junk(254, 8));
		repeat (260) send_random_tick();
		wait_drained();
	endtask

	// Random ticks over several settings, extremes first when with_extremes is set
	task automatic test_random_traffic(int snd, int rcv, int settings, int ticks_each,
		logic with_extremes);
		cvrl_pkg::cfg_t c;
		snd_idle_pct = snd;
		rcv_stall_pct = rcv;
		for (int s = 0; s < settings; s++) begin
			c = random_setting();
			if (with_extremes && s == 0)
				c = '0;
			else if (with_extremes && s == 1) begin
				c = '1;
				c.period_ticks = 8'd254;
			end else if ($urandom_range(99) < 10)
				c = CFG_AT_RESET;
			apply_setting(c);
			if ($urandom_range(99) < 30)
				write_reg(FIRST_UNUSED_INDEX + 4'($urandom_range(0, 7)), 16'($urandom));
			repeat (ticks_each) send_random_tick();
			wait_drained();
		end
	endtask

	// Receiver ready, stalling at the phase rate
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);

	// Compare each command with the oldest owed one
	always @(posedge clk) begin
		cvrl_pkg::command_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (owed_commands.size() == 0) begin
				$error("command %h with none owed", m_axis_tdata);
				errors++;
			end else begin
				want = owed_commands.pop_front();
				if (m_axis_tdata[9:0] !== want.voltage_command) begin
					$error("voltage_command: expected %0d, got %0d",
						want.voltage_command, m_axis_tdata[9:0]);
					errors++;
				end
				if (m_axis_tdata[19:10] !== want.current_command) begin
					$error("current_command: expected %0d, got %0d",
						want.current_command, m_axis_tdata[19:10]);
					errors++;
				end
				if (m_axis_tdata[20] !== want.charger_enable) begin
					$error("charger_enable: expected %0d, got %0d",
						want.charger_enable, m_axis_tdata[20]);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_values();
		test_adjust_rules();
		test_counter_wrap();
		test_random_traffic(0, 0, 5, 67, 1'b1);
		test_random_traffic(58, 0, 5, 67, 1'b0);
		test_random_traffic(0, 58, 5, 67, 1'b0);
		test_random_traffic(26, 26, 5, 67, 1'b0);
		if (errors == 0)
			$display("charger_voltage_request_loop_unit_tb: done, clean");
		else
			$display("charger_voltage_request_loop_unit_tb: done, errors");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#2000000;
		$display("charger_voltage_request_loop_unit_tb: done, errors");
		$finish;
	end

endmodule
